@@ sv/facl_pkg.sv @@
// facl_pkg: shared types and constants for the fifo associative cache lookup block
// no dependencies; imported by the core
`default_nettype none

package facl_pkg;

  localparam int CACHE_SLOTS_DEF = 16;
  localparam int STORE_DEPTH_DEF = 128;
  localparam int VALUE_BITS_DEF  = 16;

  localparam int INDEX_W = 7;
  localparam int ITEM_W  = 16;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [STAT_W-1:0] ST_HIT       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FILLED    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic               action;
    logic [INDEX_W-1:0] store_index;
    logic [ITEM_W-1:0]  item_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  cache_slot;
    logic [INDEX_W-1:0] found_index;
  } rsp_t;

endpackage

`default_nettype wire

@@ sv/facl_ram.sv @@
// facl_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module facl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/fifo_associative_cache_lookup_core.sv @@
// fifo_associative_cache_lookup_core: fully associative cache with round-robin fill
// in front of a content-searched backing store; uses facl_pkg and facl_ram
`default_nettype none

// After reset the block writes the backing store's initial contents and takes
// no item until that is done. A load item is written to the backing store as it
// is taken. A read walks the cache slots through one comparator, one slot a
// cycle; a miss then scans the backing store ram one word a cycle through the
// same comparator. The result sits in an output register, so the next item is
// taken while it waits.
module fifo_associative_cache_lookup_core #(
  parameter int CACHE_SLOTS = facl_pkg::CACHE_SLOTS_DEF,
  parameter int STORE_DEPTH = facl_pkg::STORE_DEPTH_DEF,
  parameter int VALUE_BITS  = facl_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  facl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output facl_pkg::rsp_t rsp
);

  import facl_pkg::*;

  localparam int SW = $clog2(CACHE_SLOTS);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(CACHE_SLOTS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_CNT = (AW+1)'(STORE_DEPTH);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CSCAN = 3'd2;
  localparam logic [2:0] S_SSCAN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]            state;
  logic [AW:0]           scnt;
  logic                  pend;
  logic [AW-1:0]         paddr;
  logic [SW-1:0]         ccnt;
  logic [SW-1:0]         fill_ptr;
  logic [VALUE_BITS-1:0] val_q;
  logic                  slot_valid [CACHE_SLOTS];
  logic [VALUE_BITS-1:0] slot_value [CACHE_SLOTS];
  logic [AW-1:0]         slot_idx   [CACHE_SLOTS];
  rsp_t                  res;

  logic                  accept;
  logic [31:0]           req_val32;
  logic [31:0]           req_idx32;
  logic [31:0]           init32;
  logic                  load_ok;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic [VALUE_BITS-1:0] cmp_b;
  logic                  eq;
  logic                  hit_go;
  logic                  fill_go;
  logic                  done_go;
  logic [31:0]           ccnt32;
  logic [31:0]           cidx32;
  logic [31:0]           fptr32;
  logic [31:0]           paddr32;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign req_val32 = 32'(req.item_value);
  assign req_idx32 = 32'(req.store_index);
  assign load_ok   = req_idx32 < 32'(STORE_DEPTH);
  assign init32    = 32'(STORE_DEPTH) - 32'(scnt);

  assign ram_we    = (state == S_INIT) || (accept && req.action == ACT_LOAD && load_ok);
  assign ram_waddr = (state == S_INIT) ? scnt[AW-1:0] : req_idx32[AW-1:0];
  assign ram_wdata = (state == S_INIT) ? init32[VALUE_BITS-1:0]
                                       : req_val32[VALUE_BITS-1:0];

  facl_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scnt[AW-1:0]),
    .rdata(ram_rdata)
  );

  // shared comparator: cache slot during the slot walk, store word during the scan
  assign cmp_b   = (state == S_CSCAN) ? slot_value[ccnt] : ram_rdata;
  assign eq      = (val_q == cmp_b);
  assign hit_go  = (state == S_CSCAN) && slot_valid[ccnt] && eq;
  assign fill_go = (state == S_SSCAN) && pend && eq;
  assign done_go = (state == S_DONE) && (!rsp_valid || rsp_ready);

  assign ccnt32  = 32'(ccnt);
  assign cidx32  = 32'(slot_idx[ccnt]);
  assign fptr32  = 32'(fill_ptr);
  assign paddr32 = 32'(paddr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      scnt      <= '0;
      pend      <= 1'b0;
      ccnt      <= '0;
      fill_ptr  <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else begin
      if (done_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (scnt[AW-1:0] == LAST_ADDR) begin
            scnt  <= '0;
            state <= S_IDLE;
          end else begin
            scnt <= scnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept && req.action == ACT_READ) begin
            ccnt  <= '0;
            state <= S_CSCAN;
          end
        end
        S_CSCAN: begin
          if (hit_go) begin
            state <= S_DONE;
          end else if (ccnt == LAST_SLOT) begin
            scnt  <= '0;
            pend  <= 1'b0;
            state <= S_SSCAN;
          end else begin
            ccnt <= ccnt + 1'b1;
          end
        end
        S_SSCAN: begin
          pend <= (scnt < DEPTH_CNT);
          scnt <= scnt + 1'b1;
          if (fill_go) begin
            slot_valid[fill_ptr] <= 1'b1;
            fill_ptr <= (fill_ptr == LAST_SLOT) ? '0 : fill_ptr + 1'b1;
            state    <= S_DONE;
          end else if (pend && paddr == LAST_ADDR) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_q <= req_val32[VALUE_BITS-1:0];
    end
    if (state == S_SSCAN) begin
      paddr <= scnt[AW-1:0];
    end
    if (fill_go) begin
      slot_value[fill_ptr] <= val_q;
      slot_idx[fill_ptr]   <= paddr;
    end
    if (hit_go) begin
      res.status      <= ST_HIT;
      res.cache_slot  <= ccnt32[SLOT_W-1:0];
      res.found_index <= cidx32[INDEX_W-1:0];
    end else if (fill_go) begin
      res.status      <= ST_FILLED;
      res.cache_slot  <= fptr32[SLOT_W-1:0];
      res.found_index <= paddr32[INDEX_W-1:0];
    end else if (state == S_SSCAN) begin
      res.status      <= ST_NOT_FOUND;
      res.cache_slot  <= '0;
      res.found_index <= '0;
    end
    if (done_go) begin
      rsp <= res;
    end
  end

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_LOAD) |=> !$rose(rsp_valid))
    else $error("load item produced a result");

  a_fill_ptr_range: assert property (@(posedge clk) disable iff (rst)
    fill_ptr <= LAST_SLOT)
    else $error("fill pointer beyond last slot");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_NOT_FOUND) |-> (rsp.cache_slot == '0 && rsp.found_index == '0))
    else $error("not found result carries nonzero slot or index");

  a_scan_starts_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_CSCAN && $past(state) == S_IDLE) |-> (ccnt == '0))
    else $error("slot walk did not start at slot zero");

endmodule

`default_nettype wire
